/* sv/tbps_pkg.sv */
// Shared types and constants for the token bucket packet shaper.
`default_nettype none

package tbps_pkg;

  localparam int unsigned IdW    = 16;
  localparam int unsigned TokW   = 16;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned EntryW = IdW + TokW;

  localparam logic [TokW-1:0] DepthReset = 16'd10;

  typedef enum logic [CodeW-1:0] {
    EV_TOKEN_ADDED   = 3'd0,
    EV_TOKEN_DROPPED = 3'd1,
    EV_PKT_QUEUED    = 3'd2,
    EV_PKT_FORWARDED = 3'd3,
    EV_PKT_OVERSIZE  = 3'd4,
    EV_QUEUE_FULL    = 3'd5
  } event_e;

  typedef enum logic {
    REQ_TICK    = 1'b0,
    REQ_ARRIVAL = 1'b1
  } req_e;

  // One result beat as it leaves the block.
  typedef struct packed {
    event_e          code;
    logic [IdW-1:0]  id;
    logic [TokW-1:0] level;
    logic            last;
  } result_t;

endpackage

`default_nettype wire

/* sv/token_bucket_packet_shaper.sv */
// Token bucket shaper top level: FIFO pointers, bucket and event sequencer.
// Packet arrival: first result the cycle after accept, a forward the cycle after that.
// Token tick: first result from lookup state (head entry read from the queue RAM),
// an optional forward/drop result the cycle after that; busy_o is high meanwhile.
// Rate: one arrival per cycle; ticks and forwarding arrivals hold busy_o high until the
// last result. Results cannot be stalled. Reset clears bucket, pointers, fill; depth 10.
`default_nettype none

module token_bucket_packet_shaper #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic                       req_type_i,
  input  wire logic [tbps_pkg::IdW-1:0]   packet_id_i,
  input  wire logic [tbps_pkg::TokW-1:0]  tokens_needed_i,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [tbps_pkg::TokW-1:0]  cfg_data_i,
  output logic                            result_strobe_o,
  output logic [tbps_pkg::CodeW-1:0]      event_code_o,
  output logic [tbps_pkg::IdW-1:0]        event_packet_id_o,
  output logic [tbps_pkg::TokW-1:0]       bucket_level_o,
  output logic                            last_o
);

  localparam int unsigned AddrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(QUEUE_DEPTH - 1);
  localparam logic [FillW-1:0] FullFill = FillW'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SECOND
  } state_e;

  state_e                      state_q, state_d;
  logic [tbps_pkg::TokW-1:0]   depth_q, depth_d;
  logic [tbps_pkg::TokW-1:0]   tok_q, tok_d;
  logic [AddrW-1:0]            head_q, head_d;
  logic [AddrW-1:0]            tail_q, tail_d;
  logic [FillW-1:0]            fill_q, fill_d;
  tbps_pkg::event_e            pend_code_q, pend_code_d;
  logic                        strobe_q, strobe_d;
  tbps_pkg::result_t           out_q, out_d;
  tbps_pkg::result_t           second_q, second_d;

  logic                        accept;
  logic                        ram_we, ram_re;
  logic [tbps_pkg::EntryW-1:0] ram_wdata, ram_rdata;
  logic [tbps_pkg::IdW-1:0]    head_id;
  logic [tbps_pkg::TokW-1:0]   head_need;

  function automatic logic [AddrW-1:0] bump(input logic [AddrW-1:0] ptr);
    return (ptr == LastAddr) ? '0 : ptr + 1'b1;
  endfunction

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  assign ram_we    = accept && (req_type_i == tbps_pkg::REQ_ARRIVAL) && (fill_q != FullFill);
  assign ram_re    = accept && (req_type_i == tbps_pkg::REQ_TICK);
  assign ram_wdata = {tokens_needed_i, packet_id_i};
  assign head_id   = ram_rdata[tbps_pkg::IdW-1:0];
  assign head_need = ram_rdata[tbps_pkg::EntryW-1:tbps_pkg::IdW];

  tbps_ram #(
    .Width(tbps_pkg::EntryW),
    .Depth(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    depth_d     = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : depth_q;
    tok_d       = tok_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    pend_code_d = pend_code_q;
    strobe_d    = 1'b0;
    out_d       = out_q;
    second_d    = second_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == tbps_pkg::REQ_TICK) begin
            if (tok_q >= depth_q) begin
              pend_code_d = tbps_pkg::EV_TOKEN_DROPPED;
            end else begin
              pend_code_d = tbps_pkg::EV_TOKEN_ADDED;
              tok_d       = tok_q + 1'b1;
            end
            state_d = ST_LOOKUP;
          end else if (fill_q == FullFill) begin
            strobe_d = 1'b1;
            out_d    = '{tbps_pkg::EV_QUEUE_FULL, packet_id_i, tok_q, 1'b1};
          end else begin
            strobe_d = 1'b1;
            tail_d   = bump(tail_q);
            // Alone in the queue and affordable: forward straight away.
            if (fill_q == '0 && tok_q >= tokens_needed_i) begin
              out_d    = '{tbps_pkg::EV_PKT_QUEUED, packet_id_i, tok_q, 1'b0};
              tok_d    = tok_q - tokens_needed_i;
              head_d   = bump(head_q);
              second_d = '{tbps_pkg::EV_PKT_FORWARDED, packet_id_i, tok_d, 1'b1};
              state_d  = ST_SECOND;
            end else begin
              out_d  = '{tbps_pkg::EV_PKT_QUEUED, packet_id_i, tok_q, 1'b1};
              fill_d = fill_q + 1'b1;
            end
          end
        end
      end
      ST_LOOKUP: begin
        strobe_d = 1'b1;
        out_d    = '{pend_code_q, '0, tok_q, 1'b1};
        state_d  = ST_IDLE;
        if (fill_q != '0) begin
          if (tok_q >= head_need) begin
            tok_d      = tok_q - head_need;
            head_d     = bump(head_q);
            fill_d     = fill_q - 1'b1;
            out_d.last = 1'b0;
            second_d   = '{tbps_pkg::EV_PKT_FORWARDED, head_id, tok_d, 1'b1};
            state_d    = ST_SECOND;
          end else if (depth_q < head_need) begin
            head_d     = bump(head_q);
            fill_d     = fill_q - 1'b1;
            out_d.last = 1'b0;
            second_d   = '{tbps_pkg::EV_PKT_OVERSIZE, head_id, tok_q, 1'b1};
            state_d    = ST_SECOND;
          end
        end
      end
      ST_SECOND: begin
        strobe_d = 1'b1;
        out_d    = second_q;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      depth_q     <= tbps_pkg::DepthReset;
      tok_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      pend_code_q <= tbps_pkg::EV_TOKEN_ADDED;
      strobe_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      tok_q       <= tok_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      pend_code_q <= pend_code_d;
      strobe_q    <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    second_q <= second_d;
  end

  assign result_strobe_o   = strobe_q;
  assign event_code_o      = out_q.code;
  assign event_packet_id_o = out_q.id;
  assign bucket_level_o    = out_q.level;
  assign last_o            = out_q.last;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullFill)
    else $error("queue fill exceeds depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with head and tail apart");

  a_second_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && !out_q.last) |=> strobe_q)
    else $error("non-final beat not followed by another beat");

  a_lookup_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |-> $past(ram_re))
    else $error("lookup without a queue read");

endmodule

`default_nettype wire

/* sv/tbps_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module tbps_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
